FILE: rtl/hcbp_pkg.sv
// hcbp_pkg: shared constants, command codes and inter-stage types for the
// prefix code bit packer. No dependencies; compile first.
package hcbp_pkg;

    // table geometry and field widths
    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int SYM_W        = 8;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int SYM_AW       = $clog2(SYMBOL_COUNT);
    localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // pending partial byte: up to seven bits, count 0..7
    localparam int PEND_W  = 7;
    localparam int PCNT_W  = 3;
    // staging window: seven pending bits plus a full code, rounded to bytes
    localparam int WIN_W   = 40;
    localparam int QBITS_W = 32;
    localparam int NB_W    = 3;

    // commands
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_LOAD   = 2'd0;
    localparam t_cmd CMD_ENCODE = 2'd1;
    localparam t_cmd CMD_FLUSH  = 2'd2;

    // bytes handed from the pack stage to the output register
    typedef struct packed {
        logic                vld;
        logic [QBITS_W-1:0]  bytes;
        logic [NB_W-1:0]     nbytes;
    } t_push;

endpackage

FILE: rtl/hcbp_if.sv
// hcbp_if: valid/ready channel interfaces for input requests and output bytes.
// Depends on hcbp_pkg.
interface hcbp_in_if import hcbp_pkg::*;;
    logic              valid;
    logic              ready;
    t_cmd              cmd;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, cmd, symbol, code_word, code_length, input ready);
    modport sink   (input valid, cmd, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if import hcbp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

FILE: rtl/hcbp_table.sv
// hcbp_table: code table memory (bits and length) with registered read.
// Length entries carry valid bits so unloaded symbols read as length zero.
// Depends on hcbp_pkg.
module hcbp_table import hcbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic              i_wr_en,
    input  logic [SYM_AW-1:0] i_addr,
    input  logic [CODE_W-1:0] i_wr_bits,
    input  logic [LEN_W-1:0]  i_wr_len,
    output logic [CODE_W-1:0] o_rd_bits,
    output logic [LEN_W-1:0]  o_rd_len
);

    logic [CODE_W-1:0]       r_mem_bits [SYMBOL_COUNT];
    logic [LEN_W-1:0]        r_mem_len  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_valid;
    logic [LEN_W-1:0]        wr_len_clamped;

    // clamp the loaded length to the supported code size
    assign wr_len_clamped = (i_wr_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : i_wr_len;

    // memory write port; any later read sees the write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_bits[i_addr] <= i_wr_bits;
            r_mem_len[i_addr]  <= wr_len_clamped;
        end
    end

    // per-entry valid bits for the length store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_bits <= r_mem_bits[i_addr];
            o_rd_len  <= r_valid[i_addr] ? r_mem_len[i_addr] : '0;
        end
    end

endmodule

FILE: rtl/hcbp_pack.sv
// hcbp_pack: pack stage; merges the looked-up code with the pending partial
// byte and hands whole bytes to the output register. Depends on hcbp_pkg.
module hcbp_pack import hcbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_cmd              i_cmd,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [CODE_W-1:0] i_rd_bits,
    input  logic [LEN_W-1:0]  i_rd_len,
    input  logic              i_q_free,
    output logic              o_ready,
    output t_push             o_push
);

    logic              r_s1_valid;
    t_cmd              r_cmd;
    logic              r_ok;
    logic [PEND_W-1:0] r_pend_bits;
    logic [PCNT_W-1:0] r_pend_cnt;
    logic [PEND_W-1:0] n_pend_bits;
    logic [PCNT_W-1:0] n_pend_cnt;

    logic              is_enc;
    logic [LEN_W-1:0]  clen;
    logic [LEN_W-1:0]  total;
    logic [CODE_W:0]   m33;
    logic [CODE_W-1:0] cm;
    logic [WIN_W-1:0]  wcode;
    logic [WIN_W-1:0]  wpend;
    logic [WIN_W-1:0]  win;
    logic [CODE_W+PEND_W-1:0] pshift;
    logic [PEND_W-1:0] lowv;
    logic [BYTE_W-1:0] m8;
    logic [NB_W-1:0]   nb;
    logic              adv;

    // stage register for the request whose table read is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= i_cmd;
            r_ok  <= ({1'b0, i_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
        end
    end

    // merge window: pending bits at the top, code bits right behind them
    assign is_enc = (r_cmd == CMD_ENCODE) && r_ok;
    assign clen   = is_enc ? i_rd_len : '0;
    assign total  = LEN_W'(r_pend_cnt) + clen;
    assign m33    = ((CODE_W + 1)'(1) << clen) - (CODE_W + 1)'(1);
    assign cm     = i_rd_bits & m33[CODE_W-1:0];
    assign wcode  = ({cm, 8'b0} << (LEN_W'(CODE_W) - clen)) >> r_pend_cnt;
    assign wpend  = {r_pend_bits, (WIN_W - PEND_W)'(0)} << (PCNT_W'(PEND_W) - r_pend_cnt);
    assign win    = wpend | wcode;

    // low bits that stay pending after whole bytes leave
    assign pshift = {CODE_W'(0), r_pend_bits} << clen;
    assign lowv   = pshift[PEND_W-1:0] | cm[PEND_W-1:0];
    assign m8     = (BYTE_W'(1) << total[PCNT_W-1:0]) - BYTE_W'(1);

    // byte count and next pending state per command
    always_comb begin
        nb          = '0;
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        unique case (r_cmd)
            CMD_ENCODE: begin
                if (r_ok) begin
                    nb          = total[LEN_W-1:PCNT_W];
                    n_pend_bits = lowv & m8[PEND_W-1:0];
                    n_pend_cnt  = total[PCNT_W-1:0];
                end
            end
            CMD_FLUSH: begin
                nb          = (r_pend_cnt != '0) ? NB_W'(1) : '0;
                n_pend_bits = '0;
                n_pend_cnt  = '0;
            end
            default: begin
            end
        endcase
    end

    // advance when no bytes result or the output register takes them
    assign adv     = r_s1_valid && ((nb == '0) || i_q_free);
    assign o_ready = !r_s1_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else if (adv) begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    assign o_push.vld    = adv && (nb != '0);
    assign o_push.bytes  = win[WIN_W-1:WIN_W-QBITS_W];
    assign o_push.nbytes = nb;

    // pending bits above the pending count stay clear
    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_bits >> r_pend_cnt) == '0)
        else $error("pending bits set above pending count");

    // a byte handoff carries one to four bytes
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.vld |-> (o_push.nbytes != '0) && (o_push.nbytes <= NB_W'(4)))
        else $error("byte handoff count out of range");

endmodule

FILE: rtl/hcbp_outq.sv
// hcbp_outq: output register holding up to four packed bytes, drained one
// request per cycle while the sink is ready, earliest byte first. Depends on hcbp_pkg, hcbp_if.
module hcbp_outq import hcbp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_push              i_push,
    output logic               o_free,
    hcbp_out_if.source         o_out
);

    logic [QBITS_W-1:0] r_bytes;
    logic [NB_W-1:0]    r_cnt;
    logic               pop;

    assign pop    = o_out.valid && o_out.ready;
    assign o_free = (r_cnt == '0) || ((r_cnt == NB_W'(1)) && o_out.ready);

    // byte count: load on handoff, count down on each taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_push.vld) begin
            r_cnt <= i_push.nbytes;
        end else if (pop) begin
            r_cnt <= r_cnt - NB_W'(1);
        end
    end

    // byte data shifts up so the next byte sits at the top
    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_bytes <= i_push.bytes;
        end else if (pop) begin
            r_bytes <= {r_bytes[QBITS_W-BYTE_W-1:0], BYTE_W'(0)};
        end
    end

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_byte = r_bytes[QBITS_W-1:QBITS_W-BYTE_W];
    assign o_out.last     = (r_cnt == NB_W'(1));

    // never more than four bytes held
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NB_W'(4))
        else $error("output byte count out of range");

    // a handoff only arrives when held bytes are gone or going
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld |-> o_free)
        else $error("byte handoff overwrote held bytes");

    // after a handoff the count equals the bytes handed over
    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld |=> r_cnt == $past(i_push.nbytes))
        else $error("byte count did not load from handoff");

endmodule

FILE: rtl/huffman_code_bit_packer.sv
// huffman_code_bit_packer: top level. The table is read on acceptance; the pack
// stage hands merged bytes to the output register. Throughput: one request per
// cycle while each yields at most one byte and the sink is ready; a multi-byte
// request holds the output register until its last byte is taken. Reset (sync,
// active low) clears pending bits, pipeline valids and the length valid bits at
// once; no clearing pass. Depends on hcbp_pkg, hcbp_if and the three submodules.
module huffman_code_bit_packer import hcbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbp_in_if.sink     i_in,
    hcbp_out_if.source  o_out
);

    logic              accept;
    logic              ready;
    logic              q_free;
    logic              wr_en;
    logic [CODE_W-1:0] rd_bits;
    logic [LEN_W-1:0]  rd_len;
    t_push             push;

    assign i_in.ready = ready;
    assign accept     = i_in.valid && ready;
    assign wr_en      = accept && (i_in.cmd == CMD_LOAD)
                        && ({1'b0, i_in.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));

    // code table lookup / load
    hcbp_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_wr_en   (wr_en),
        .i_addr    (i_in.symbol[SYM_AW-1:0]),
        .i_wr_bits (i_in.code_word),
        .i_wr_len  (i_in.code_length),
        .o_rd_bits (rd_bits),
        .o_rd_len  (rd_len)
    );

    // bit merge with the pending partial byte
    hcbp_pack u_pack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_cmd     (i_in.cmd),
        .i_symbol  (i_in.symbol),
        .i_rd_bits (rd_bits),
        .i_rd_len  (rd_len),
        .i_q_free  (q_free),
        .o_ready   (ready),
        .o_push    (push)
    );

    // output byte register
    hcbp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (q_free),
        .o_out   (o_out)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for huffman_code_bit_packer, directed table then random requests.
// Depends on hcbp_pkg and the hcbp_in_if / hcbp_out_if channel interfaces.
module tb;
    import hcbp_pkg::*;

    // command value with no meaning to the block
    localparam t_cmd CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_AT      = 150;   // request count at which the sink holds off
    localparam int CALM_END     = 210;   // no sender gaps up to here; the sink is ready but for its hold-off
    localparam int SINK_HOLD    = 300;   // cycles of the long sink hold-off
    localparam int DRAIN_AT     = 330;   // sender pauses here until all bytes are in
    localparam int DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hcbp_in_if  req_ch ();
    hcbp_out_if byte_ch ();

    huffman_code_bit_packer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (byte_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // directed stimulus; fixed rows carry the bytes expected at a glance
    typedef struct packed {
        t_cmd              cmd;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic              fixed;
        logic [2:0]        nfix;
        logic [31:0]       fix_bytes;
    } t_dir_row;

    localparam int DIR_ROWS = 26;
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{CMD_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},          // unloaded
        '{CMD_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},          // empty
        '{CMD_UNUSED, 8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},
        '{CMD_LOAD,   8'd0,   32'h0000_00A5, 6'd8,  1'b1, 3'd0, 32'h0},
        '{CMD_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hA500_0000},
        '{CMD_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0},
        '{CMD_ENCODE, 8'd255, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF},
        '{CMD_LOAD,   8'd1,   32'hFFFF_FFFF, 6'd1,  1'b1, 3'd0, 32'h0},          // code "1"
        '{CMD_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},
        '{CMD_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h8000_0000},
        '{CMD_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},
        '{CMD_LOAD,   8'd2,   32'h1234_5678, 6'd0,  1'b1, 3'd0, 32'h0},          // zero length
        '{CMD_ENCODE, 8'd2,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},
        '{CMD_LOAD,   8'd3,   32'hDEAD_BEEF, 6'd63, 1'b1, 3'd0, 32'h0},          // clamped
        '{CMD_LOAD,   8'd5,   32'h0000_0000, 6'd32, 1'b1, 3'd0, 32'h0},
        '{CMD_ENCODE, 8'd5,   32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'h0000_0000},
        '{CMD_ENCODE, 8'd3,   32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hDEAD_BEEF},
        '{CMD_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
        '{CMD_ENCODE, 8'd3,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
        '{CMD_UNUSED, 8'hAA,  32'h5555_AAAA, 6'h2A, 1'b0, 3'd0, 32'h0},
        '{CMD_LOAD,   8'd4,   32'h0000_0005, 6'd3,  1'b0, 3'd0, 32'h0},
        '{CMD_ENCODE, 8'd4,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
        '{CMD_ENCODE, 8'd4,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
        '{CMD_LOAD,   8'd128, 32'hFFFF_FF7F, 6'd7,  1'b0, 3'd0, 32'h0},
        '{CMD_ENCODE, 8'd128, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
        '{CMD_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0}
    };

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_packed_byte;

    // predictor state: code table and the partial byte
    logic [CODE_W-1:0] code_bits [SYMBOL_COUNT];
    logic [LEN_W-1:0]  code_len  [SYMBOL_COUNT];
    logic [PEND_W-1:0] pend_bits;
    int                pend_cnt;
    logic [BYTE_W-1:0] fresh_bytes [4];

    t_packed_byte bytes_due_q [$];

    int  fail_cnt    = 0;
    int  bytes_seen  = 0;
    int  req_total   = 0;
    int  req_by_cmd [4] = '{0, 0, 0, 0};
    bit  calm        = 1'b0;
    logic hold_req   = 1'b0;

    // packs one request into output bytes, returns how many it emits
    function automatic int pack_request(input t_cmd c, input logic [SYM_W-1:0] sym,
                                        input logic [CODE_W-1:0] word,
                                        input logic [LEN_W-1:0] len);
        int                n;
        int                cnt;
        logic [7:0]        acc;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  clen;
        n = 0;
        case (c)
            CMD_LOAD: begin
                if (int'(sym) < SYMBOL_COUNT) begin
                    clen = (int'(len) > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
                    code_bits[sym] = word;
                    code_len[sym]  = clen;
                end
            end
            CMD_ENCODE: begin
                if (int'(sym) < SYMBOL_COUNT) begin
                    bits = code_bits[sym];
                    acc  = {1'b0, pend_bits};
                    cnt  = pend_cnt;
                    for (int i = int'(code_len[sym]); i > 0; i--) begin
                        acc = {acc[6:0], bits[i-1]};
                        cnt++;
                        if (cnt == 8) begin
                            if (n < 4) begin
                                fresh_bytes[n] = acc;
                                n++;
                            end
                            acc = '0;
                            cnt = 0;
                        end
                    end
                    pend_bits = acc[6:0];
                    pend_cnt  = cnt;
                end
            end
            CMD_FLUSH: begin
                if (pend_cnt > 0) begin
                    fresh_bytes[0] = {1'b0, pend_bits} << (8 - pend_cnt);
                    n = 1;
                    pend_bits = '0;
                    pend_cnt  = 0;
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // idle length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // code length for a random load, overlong now and then
    function automatic logic [LEN_W-1:0] pick_code_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 70) return LEN_W'($urandom_range(1, 8));
        if (r < 90) return LEN_W'($urandom_range(9, 20));
        if (r < 97) return LEN_W'($urandom_range(21, 32));
        return LEN_W'($urandom_range(33, 63));
    endfunction

    // offers one request, waits for it to be taken, then records its bytes
    task automatic send_request(input t_cmd c, input logic [SYM_W-1:0] sym,
                                input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len,
                                input bit fixed, input int nfix, input logic [31:0] fix_bytes);
        int gap;
        int n;
        bit drain;
        calm  = (req_total >= HOLD_AT) && (req_total < CALM_END);
        drain = (req_total == DRAIN_AT);
        gap   = calm ? 0 : pick_gap();
        if (req_total == HOLD_AT) hold_req <= 1'b1;
        // sender pause until every due byte has come out
        if (drain) begin
            while (bytes_due_q.size() != 0) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= c;
        req_ch.symbol      <= sym;
        req_ch.code_word   <= word;
        req_ch.code_length <= len;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        n = pack_request(c, sym, word, len);
        if (fixed) begin
            for (int k = 0; k < nfix; k++)
                bytes_due_q.push_back('{fix_bytes[31-8*k -: 8], k == nfix - 1});
        end else begin
            for (int k = 0; k < n; k++)
                bytes_due_q.push_back('{fresh_bytes[k], k == n - 1});
        end
        req_total++;
        req_by_cmd[c]++;
    endtask

    // output side: random ready runs and gaps, one long hold-off on request
    int  sink_left = 0;
    int  hold_left = 0;
    bit  hold_taken = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.ready <= 1'b0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = SINK_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                byte_ch.ready <= 1'b0;
            end else if (calm) begin
                byte_ch.ready <= 1'b1;
                sink_left = 0;
            end else if (sink_left > 0) begin
                sink_left--;
            end else if (byte_ch.ready) begin
                sink_left = pick_gap();
                if (sink_left > 0) begin
                    byte_ch.ready <= 1'b0;
                    sink_left--;
                end else begin
                    sink_left = $urandom_range(0, 15);
                end
            end else begin
                byte_ch.ready <= 1'b1;
                sink_left = $urandom_range(0, 15);
            end
        end
    end

    // compare every accepted byte with the oldest one due
    always @(posedge i_clk) begin
        t_packed_byte due;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            bytes_seen++;
            if (bytes_due_q.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                         $realtime, byte_ch.out_byte, byte_ch.last);
                fail_cnt++;
            end else begin
                due = bytes_due_q.pop_front();
                if (byte_ch.out_byte !== due.value) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $realtime, due.value, byte_ch.out_byte);
                    fail_cnt++;
                end
                if (byte_ch.last !== due.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $realtime, due.last, byte_ch.last);
                    fail_cnt++;
                end
            end
        end
    end

    // overall time limit
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // reset, directed table, random episodes, drain and verdict
    initial begin
        logic [SYM_W-1:0] alpha_q [$];
        logic [SYM_W-1:0] sym;
        int               nsym;
        int               nenc;
        int               r;

        for (int s = 0; s < SYMBOL_COUNT; s++) begin
            code_bits[s] = '0;
            code_len[s]  = '0;
        end
        pend_bits = '0;
        pend_cnt  = 0;

        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.cmd         <= CMD_LOAD;
        req_ch.symbol      <= '0;
        req_ch.code_word   <= '0;
        req_ch.code_length <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (dir_rows[i])
            send_request(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].word, dir_rows[i].len,
                         dir_rows[i].fixed, int'(dir_rows[i].nfix), dir_rows[i].fix_bytes);

        // random episodes: load a small alphabet, encode mostly from it
        while (req_total < DIR_ROWS + RANDOM_ITEMS) begin
            alpha_q.delete();
            nsym = $urandom_range(1, 8);
            for (int k = 0; k < nsym; k++) begin
                sym = SYM_W'($urandom_range(0, SYMBOL_COUNT - 1));
                alpha_q.push_back(sym);
                send_request(CMD_LOAD, sym, $urandom, pick_code_len(), 1'b0, 0, '0);
            end
            nenc = $urandom_range(4, 24);
            for (int k = 0; k < nenc; k++) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    send_request(CMD_ENCODE, alpha_q[$urandom_range(0, alpha_q.size() - 1)],
                                 $urandom, LEN_W'($urandom), 1'b0, 0, '0);
                else if (r < 83)
                    send_request(CMD_ENCODE, SYM_W'($urandom), $urandom, LEN_W'($urandom),
                                 1'b0, 0, '0);
                else if (r < 90)
                    send_request(CMD_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom),
                                 1'b0, 0, '0);
                else if (r < 95)
                    send_request(CMD_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom),
                                 1'b0, 0, '0);
                else
                    send_request(CMD_LOAD, SYM_W'($urandom), $urandom, pick_code_len(),
                                 1'b0, 0, '0);
            end
            if ($urandom_range(0, 3) != 0)
                send_request(CMD_FLUSH, '0, '0, '0, 1'b0, 0, '0);
        end

        // wait out the remaining bytes
        req_ch.valid <= 1'b0;
        while (bytes_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d loads, %0d encodes, %0d flushes, %0d unused.",
                 req_total, req_by_cmd[CMD_LOAD], req_by_cmd[CMD_ENCODE],
                 req_by_cmd[CMD_FLUSH], req_by_cmd[CMD_UNUSED]);
        $display("Checked %0d packed bytes, %0d mismatches.", bytes_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/hcbp_pkg.sv
rtl/hcbp_if.sv
rtl/hcbp_table.sv
rtl/hcbp_pack.sv
rtl/hcbp_outq.sv
rtl/huffman_code_bit_packer.sv
verif/tb.sv
